// ===== hdl/touch_zone_debounce_qualifier_macros.svh =====
// Assertion macros used by the touch zone debounce qualifier checker.
`ifndef TOUCH_ZONE_DEBOUNCE_QUALIFIER_MACROS_SVH
`define TOUCH_ZONE_DEBOUNCE_QUALIFIER_MACROS_SVH

// Overlapping implication, checked outside of reset.
`define TZDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch zone qualifier: property violated");

// Next-cycle implication, checked outside of reset.
`define TZDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch zone qualifier: property violated");

// Next-cycle implication that is also checked while reset is applied.
`define TZDQ_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("touch zone qualifier: property violated");

`endif

// ===== hdl/tzdq_pkg.sv =====
// Shared types and constants of the touch zone debounce qualifier.
package tzdq_pkg;

   localparam int COUNT_BITS     = 4;
   localparam int TIME_BITS      = 32;
   localparam int DEBOUNCE_BITS  = 16;
   localparam int ZONE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTION_Y_MIN  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTION_Y_MAX  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANCEL_X_MAX  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_X_MIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_X_MAX = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME = 3'd5;

   // Reset values of the configuration registers.
   localparam int RST_ACTION_Y_MIN  = 240;
   localparam int RST_ACTION_Y_MAX  = 319;
   localparam int RST_CANCEL_X_MAX  = 79;
   localparam int RST_CONFIRM_X_MIN = 92;
   localparam int RST_CONFIRM_X_MAX = 171;
   localparam logic [DEBOUNCE_BITS-1:0] RST_DEBOUNCE_TIME = 16'd30;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_ACTIVE   = 2'd2,
      PH_BLOCKED  = 2'd3
   } phase_type;

   typedef enum logic [ZONE_BITS-1:0] {
      ZONE_NONE    = 2'd0,
      ZONE_CANCEL  = 2'd1,
      ZONE_CONFIRM = 2'd2
   } zone_type;

   // One classified touch report handed to the phase machine.
   typedef struct packed {
      logic [COUNT_BITS-1:0] finger_count;
      zone_type              zone;
      logic [TIME_BITS-1:0]  timestamp;
   } report_type;

   // Zones reported for one transaction.
   typedef struct packed {
      zone_type held_zone;
      zone_type released_zone;
   } result_type;

endpackage

// ===== hdl/tzdq_zone_classifier.sv =====
// Zone classifier: maps a single-finger touch position onto the button zones.
module tzdq_zone_classifier #(
   parameter int COORD_BITS = 10
) (
   input  logic [tzdq_pkg::COUNT_BITS-1:0] finger_count,
   input  logic [COORD_BITS-1:0]           pos_x,
   input  logic [COORD_BITS-1:0]           pos_y,
   input  logic [COORD_BITS-1:0]           action_y_min,
   input  logic [COORD_BITS-1:0]           action_y_max,
   input  logic [COORD_BITS-1:0]           cancel_x_max,
   input  logic [COORD_BITS-1:0]           confirm_x_min,
   input  logic [COORD_BITS-1:0]           confirm_x_max,
   output tzdq_pkg::zone_type              zone
);
   import tzdq_pkg::*;

   logic in_band;

   assign in_band = (pos_y >= action_y_min) && (pos_y <= action_y_max);

   // Cancel wins where the two column ranges overlap.
   always_comb begin
      zone = ZONE_NONE;
      if (finger_count == COUNT_BITS'(1) && in_band) begin
         if (pos_x <= cancel_x_max) begin
            zone = ZONE_CANCEL;
         end else if (pos_x >= confirm_x_min && pos_x <= confirm_x_max) begin
            zone = ZONE_CONFIRM;
         end
      end
   end

endmodule

// ===== hdl/tzdq_phase_fsm.sv =====
// Phase machine that qualifies a touch: idle, debounce, active and blocked.
module tzdq_phase_fsm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  tzdq_pkg::report_type                report,
   input  logic [tzdq_pkg::DEBOUNCE_BITS-1:0]  debounce_time,
   output tzdq_pkg::result_type                result
);
   import tzdq_pkg::*;

   phase_type              phase_ff, phase_in;
   zone_type               candidate_ff, candidate_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   released;
   logic                   single_same;

   // Wrapping subtraction gives the held time across a timestamp rollover.
   assign elapsed     = report.timestamp - start_ff;
   assign released    = (report.finger_count == '0);
   assign single_same = (report.finger_count == COUNT_BITS'(1)) && (report.zone == candidate_ff);

   always_comb begin
      phase_in     = phase_ff;
      candidate_in = candidate_ff;
      start_in     = start_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (!released) begin
               candidate_in = report.zone;
               start_in     = report.timestamp;
               phase_in     = (report.zone == ZONE_NONE) ? PH_BLOCKED : PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (released) begin
               phase_in = PH_IDLE;
            end else if (!single_same) begin
               phase_in = PH_BLOCKED;
            end else if (elapsed >= TIME_BITS'(debounce_time)) begin
               phase_in = PH_ACTIVE;
            end
         end
         PH_ACTIVE: begin
            if (released) begin
               phase_in = PH_IDLE;
            end else if (!single_same) begin
               phase_in = PH_BLOCKED;
            end
         end
         PH_BLOCKED: begin
            if (released) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      result.held_zone     = (phase_in == PH_ACTIVE) ? candidate_in : ZONE_NONE;
      result.released_zone = (phase_ff == PH_ACTIVE && released) ? candidate_ff : ZONE_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         candidate_ff <= ZONE_NONE;
         start_ff     <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         candidate_ff <= candidate_in;
         start_ff     <= start_in;
      end
   end

endmodule

// ===== hdl/touch_zone_debounce_qualifier.sv =====
// Top level of the touch zone debounce qualifier: ports, registers and handshakes.
// Each request transaction carries one touch report (finger count, column, row and a
// wrapping millisecond timestamp) and produces exactly one response transaction with
// the held zone and the cleanly released zone (0 none, 1 cancel, 2 confirm). A single
// finger inside the button band is classified as cancel or confirm from the configured
// bounds; it becomes held once it has stayed in the same zone for debounce_time ms,
// measured with modulo 2^32 subtraction, and a release from the held state reports the
// zone once. Extra fingers, leaving the zone or starting outside every zone block the
// touch until all fingers lift. The block takes one transaction per clock cycle while
// the response channel is not stalled. A request is captured in an input register, and
// the classification and the state update run combinationally between that register
// and the response register, which holds a finished response until the consumer takes
// it. The input register advances whenever the response register is empty or being
// emptied, and an empty input register takes a new request while a finished response is
// still waiting. Configuration registers are written through the csr_ port at any clock
// edge with csr_we high and should only be changed while no transaction is in flight.
module touch_zone_debounce_qualifier #(
   parameter int COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata, lowest bit first: finger_count, pos_x, pos_y, timestamp, zero fill.
   input  logic [8*((4+2*COORD_BITS+32+7)/8)-1:0] req_tdata,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata, lowest bit first: held_zone, released_zone, zero fill.
   output logic [tzdq_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [tzdq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tzdq_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tzdq_pkg::*;

   localparam int X_LSB = COUNT_BITS;
   localparam int Y_LSB = X_LSB + COORD_BITS;
   localparam int T_LSB = Y_LSB + COORD_BITS;

   // Configuration registers.
   logic [COORD_BITS-1:0]    action_y_min_ff;
   logic [COORD_BITS-1:0]    action_y_max_ff;
   logic [COORD_BITS-1:0]    cancel_x_max_ff;
   logic [COORD_BITS-1:0]    confirm_x_min_ff;
   logic [COORD_BITS-1:0]    confirm_x_max_ff;
   logic [DEBOUNCE_BITS-1:0] debounce_time_ff;

   // Input register.
   logic                     req_valid_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COORD_BITS-1:0]    pos_x_ff;
   logic [COORD_BITS-1:0]    pos_y_ff;
   logic [TIME_BITS-1:0]     time_ff;

   // Response register.
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                     rsp_space;
   logic                     step;
   logic                     req_take;
   zone_type                 zone;
   report_type               report;
   result_type               result;

   // The state machine advances exactly when the buffered request moves into the
   // response register, so each request updates the state once.
   assign rsp_space  = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && rsp_space;
   assign req_tready = !req_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         action_y_min_ff  <= COORD_BITS'(RST_ACTION_Y_MIN);
         action_y_max_ff  <= COORD_BITS'(RST_ACTION_Y_MAX);
         cancel_x_max_ff  <= COORD_BITS'(RST_CANCEL_X_MAX);
         confirm_x_min_ff <= COORD_BITS'(RST_CONFIRM_X_MIN);
         confirm_x_max_ff <= COORD_BITS'(RST_CONFIRM_X_MAX);
         debounce_time_ff <= RST_DEBOUNCE_TIME;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTION_Y_MIN:  action_y_min_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_ACTION_Y_MAX:  action_y_max_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_CANCEL_X_MAX:  cancel_x_max_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_CONFIRM_X_MIN: confirm_x_min_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_CONFIRM_X_MAX: confirm_x_max_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_DEBOUNCE_TIME: debounce_time_ff <= csr_wdata[DEBOUNCE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: the payload loads on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         count_ff <= req_tdata[COUNT_BITS-1:0];
         pos_x_ff <= req_tdata[X_LSB +: COORD_BITS];
         pos_y_ff <= req_tdata[Y_LSB +: COORD_BITS];
         time_ff  <= req_tdata[T_LSB +: TIME_BITS];
      end
   end

   tzdq_zone_classifier #(
      .COORD_BITS (COORD_BITS)
   ) u_classifier (
      .finger_count  (count_ff),
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .action_y_min  (action_y_min_ff),
      .action_y_max  (action_y_max_ff),
      .cancel_x_max  (cancel_x_max_ff),
      .confirm_x_min (confirm_x_min_ff),
      .confirm_x_max (confirm_x_max_ff),
      .zone          (zone)
   );

   assign report.finger_count = count_ff;
   assign report.zone         = zone;
   assign report.timestamp    = time_ff;

   tzdq_phase_fsm u_phase_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .report        (report),
      .debounce_time (debounce_time_ff),
      .result        (result)
   );

   assign rsp_data_in = {(RSP_DATA_BITS - 2*ZONE_BITS)'(0),
                         result.released_zone, result.held_zone};

   // Response register: holds a finished result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_space) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/tzdq_checker.sv =====
// Port-level checker of the touch zone debounce qualifier and its bind.
`include "touch_zone_debounce_qualifier_macros.svh"

module tzdq_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tzdq_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tzdq_pkg::*;

   logic [ZONE_BITS-1:0] held;
   logic [ZONE_BITS-1:0] rel;

   assign held = rsp_tdata[ZONE_BITS-1:0];
   assign rel  = rsp_tdata[2*ZONE_BITS-1:ZONE_BITS];

   // No response may be pending in the cycle after reset.
   `TZDQ_ASSERT_ALWAYS_NEXT(a_idle_after_reset, clock, reset, !rsp_tvalid)

   // A response never carries a zone code outside none, cancel and confirm.
   `TZDQ_ASSERT_NOW(a_zone_codes, clock, reset, rsp_tvalid, (held != ZONE_BITS'(3)) && (rel != ZONE_BITS'(3)))

   // A release returns the machine to idle, so nothing is held at the same time.
   `TZDQ_ASSERT_NOW(a_release_not_held, clock, reset, rsp_tvalid && (rel != '0), held == '0)

   // A stalled response keeps its data.
   `TZDQ_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind touch_zone_debounce_qualifier tzdq_checker u_tzdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/touch_zone_debounce_qualifier_test.sv =====
// Self-checking testbench for the touch zone debounce qualifier.
`timescale 1ns / 100ps

module touch_zone_debounce_qualifier_test;
   import tzdq_pkg::*;

   localparam int COORD_W      = 10;
   localparam int REQ_BITS     = 8*((COUNT_BITS+2*COORD_W+TIME_BITS+7)/8);
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;
   // Longest correct stretch without any transaction is a sender gap plus a receiver
   // stall plus the pipeline registers and the pause around a register update, so this
   // limit leaves a wide margin.
   localparam int QUIET_LIMIT  = 2000;

   // One touch report. The last field sits in the lowest bits, so the packed struct
   // is the request tdata layout as it stands.
   typedef struct packed {
      logic [TIME_BITS-1:0]  timestamp;
      logic [COORD_W-1:0]    pos_y;
      logic [COORD_W-1:0]    pos_x;
      logic [COUNT_BITS-1:0] finger_count;
   } touch_report;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // tdata, lowest bit first: finger_count, pos_x, pos_y, timestamp.
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // tdata, lowest bit first: held_zone, released_zone, zero fill.
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   touch_zone_debounce_qualifier #(
      .COORD_BITS(COORD_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Our own copy of the configuration, starting from the reset values of the block.
   logic [COORD_W-1:0]       cfg_y_min      = COORD_W'(RST_ACTION_Y_MIN);
   logic [COORD_W-1:0]       cfg_y_max      = COORD_W'(RST_ACTION_Y_MAX);
   logic [COORD_W-1:0]       cfg_cancel_max = COORD_W'(RST_CANCEL_X_MAX);
   logic [COORD_W-1:0]       cfg_confirm_min = COORD_W'(RST_CONFIRM_X_MIN);
   logic [COORD_W-1:0]       cfg_confirm_max = COORD_W'(RST_CONFIRM_X_MAX);
   logic [DEBOUNCE_BITS-1:0] cfg_debounce   = RST_DEBOUNCE_TIME;

   // Our own copy of the qualifier state.
   phase_type             tz_phase      = PH_IDLE;
   zone_type              tz_candidate  = ZONE_NONE;
   logic [TIME_BITS-1:0]  tz_press_time = '0;

   touch_report pending_reports[$];
   result_type  expected_zones[$];
   touch_report in_flight;

   int send_gap = 0;
   int stall_left = 0;
   int gap_odds = 0;         // one chance in gap_odds to start a sender gap, 0 = never
   int stall_odds = 0;       // same for receiver stalls
   int mismatches = 0;
   int reports_accepted = 0;
   int held_seen = 0;
   int released_seen = 0;
   int settings_applied = 0;
   int phase_items = 0;
   int quiet_cycles = 0;
   logic [TIME_BITS-1:0] touch_time = '0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Zone of a single finger at (x, y). Cancel wins where the two zones overlap, and an
   // inverted range simply matches nothing.
   function automatic zone_type zone_of(input logic [COORD_W-1:0] x, y);
      if (y < cfg_y_min || y > cfg_y_max) return ZONE_NONE;
      if (x <= cfg_cancel_max) return ZONE_CANCEL;
      if (x >= cfg_confirm_min && x <= cfg_confirm_max) return ZONE_CONFIRM;
      return ZONE_NONE;
   endfunction

   // Advances the qualifier state by one report and returns the zones it reports.
   function automatic result_type qualify_report(input touch_report r);
      zone_type             zone;
      result_type           res;
      logic [TIME_BITS-1:0] elapsed;
      zone = (r.finger_count == 1) ? zone_of(r.pos_x, r.pos_y) : ZONE_NONE;
      res.held_zone = ZONE_NONE;
      res.released_zone = ZONE_NONE;
      // Elapsed time wraps modulo 2^32 with the timestamp counter.
      elapsed = r.timestamp - tz_press_time;
      case (tz_phase)
         PH_IDLE: begin
            if (r.finger_count != 0) begin
               tz_candidate = zone;
               tz_press_time = r.timestamp;
               tz_phase = (zone == ZONE_NONE) ? PH_BLOCKED : PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (r.finger_count == 0) tz_phase = PH_IDLE;
            else if (r.finger_count != 1 || zone != tz_candidate) tz_phase = PH_BLOCKED;
            else if (elapsed >= TIME_BITS'(cfg_debounce)) tz_phase = PH_ACTIVE;
         end
         PH_ACTIVE: begin
            if (r.finger_count == 0) begin
               res.released_zone = tz_candidate;
               tz_phase = PH_IDLE;
            end else if (r.finger_count != 1 || zone != tz_candidate) begin
               tz_phase = PH_BLOCKED;
            end
         end
         default: begin
            if (r.finger_count == 0) tz_phase = PH_IDLE;
         end
      endcase
      if (tz_phase == PH_ACTIVE) res.held_zone = tz_candidate;
      return res;
   endfunction

   // Request driver. A report is presented from the queue and held until accepted;
   // the prediction is made at the edge where the transaction takes place.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_zones.push_back(qualify_report(in_flight));
            reports_accepted++;
         end
         if (send_gap == 0 && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            send_gap = $urandom_range(1, 17);
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reports.size() != 0) begin
            in_flight = pending_reports.pop_front();
            req_tdata <= REQ_BITS'(in_flight);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor. Every response transaction is matched against the oldest
   // outstanding prediction, field by field.
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tdata[1:0] != ZONE_NONE) held_seen++;
            if (rsp_tdata[3:2] != ZONE_NONE) released_seen++;
            if (expected_zones.size() == 0) begin
               report_mismatch($sformatf("response 0x%0h with nothing outstanding",
                                         rsp_tdata));
            end else begin
               want = expected_zones.pop_front();
               if (rsp_tdata[1:0] !== want.held_zone)
                  report_mismatch($sformatf("held_zone %0d, expected %0d",
                                            rsp_tdata[1:0], want.held_zone));
               if (rsp_tdata[3:2] !== want.released_zone)
                  report_mismatch($sformatf("released_zone %0d, expected %0d",
                                            rsp_tdata[3:2], want.released_zone));
               if (rsp_tdata[RSP_DATA_BITS-1:4] !== '0)
                  report_mismatch($sformatf("fill bits of response are 0x%0h",
                                            rsp_tdata[RSP_DATA_BITS-1:4]));
            end
         end
         if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            stall_left = $urandom_range(1, 17);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any transaction or register write counts as progress.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic queue_report(input logic [COUNT_BITS-1:0] count,
                               input logic [COORD_W-1:0] x, y,
                               input logic [TIME_BITS-1:0] ts);
      touch_report r;
      r.finger_count = count;
      r.pos_x = x;
      r.pos_y = y;
      r.timestamp = ts;
      pending_reports.push_back(r);
      phase_items++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_ACTION_Y_MIN:  cfg_y_min = value[COORD_W-1:0];
         CSR_ACTION_Y_MAX:  cfg_y_max = value[COORD_W-1:0];
         CSR_CANCEL_X_MAX:  cfg_cancel_max = value[COORD_W-1:0];
         CSR_CONFIRM_X_MIN: cfg_confirm_min = value[COORD_W-1:0];
         CSR_CONFIRM_X_MAX: cfg_confirm_max = value[COORD_W-1:0];
         CSR_DEBOUNCE_TIME: cfg_debounce = value[DEBOUNCE_BITS-1:0];
         default: ;
      endcase
   endtask

   // Writes all six registers back to back; only called while the block is idle.
   task automatic apply_settings(input int y_lo, y_hi, c_hi, f_lo, f_hi, hold_ms);
      write_register(CSR_ACTION_Y_MIN, CSR_DATA_BITS'(y_lo));
      write_register(CSR_ACTION_Y_MAX, CSR_DATA_BITS'(y_hi));
      write_register(CSR_CANCEL_X_MAX, CSR_DATA_BITS'(c_hi));
      write_register(CSR_CONFIRM_X_MIN, CSR_DATA_BITS'(f_lo));
      write_register(CSR_CONFIRM_X_MAX, CSR_DATA_BITS'(f_hi));
      write_register(CSR_DEBOUNCE_TIME, CSR_DATA_BITS'(hold_ms));
      @(posedge clock);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // The sender holds off until every predicted response has come back, then lets the
   // pipeline settle a little longer.
   task automatic wait_for_drain();
      while (pending_reports.size() != 0 || req_tvalid || expected_zones.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // A point inside the given zone under the current settings, where one exists.
   task automatic pick_point(input zone_type aim,
                             output logic [COORD_W-1:0] x, y);
      x = COORD_W'($urandom_range(0, 1023));
      y = COORD_W'($urandom_range(0, 1023));
      if (aim != ZONE_NONE && cfg_y_min <= cfg_y_max) begin
         y = COORD_W'($urandom_range(cfg_y_min, cfg_y_max));
         if (aim == ZONE_CANCEL)
            x = COORD_W'($urandom_range(0, cfg_cancel_max));
         else if (cfg_confirm_min <= cfg_confirm_max)
            x = COORD_W'($urandom_range(cfg_confirm_min, cfg_confirm_max));
      end
   endtask

   // Time between two reports of one touch, spread around the debounce threshold,
   // with an occasional huge jump that wraps the millisecond counter.
   function automatic logic [TIME_BITS-1:0] hold_step();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 1;
         2: return TIME_BITS'(cfg_debounce);
         3: return TIME_BITS'(cfg_debounce >> 1);
         4: return TIME_BITS'($urandom_range(0, 2*cfg_debounce + 1));
         5: return TIME_BITS'(cfg_debounce) + TIME_BITS'($urandom_range(1, 40));
         default: return $urandom;
      endcase
   endfunction

   // One press-hold-release sequence: mostly well formed, sometimes disturbed by extra
   // fingers or a slide into the other zone before the lift.
   task automatic queue_gesture();
      zone_type           aim;
      zone_type           stray;
      logic [COORD_W-1:0] x, y;
      int                 holds;
      case ($urandom_range(0, 9))
         0: aim = ZONE_NONE;
         1, 2, 3, 4: aim = ZONE_CANCEL;
         default: aim = ZONE_CONFIRM;
      endcase
      pick_point(aim, x, y);
      if ($urandom_range(0, 11) == 0)
         queue_report(COUNT_BITS'($urandom_range(2, 15)), x, y, touch_time);
      else
         queue_report(1, x, y, touch_time);
      holds = $urandom_range(0, 6);
      repeat (holds) begin
         touch_time += hold_step();
         if ($urandom_range(0, 3) == 0) pick_point(aim, x, y);
         queue_report(1, x, y, touch_time);
      end
      if ($urandom_range(0, 4) == 0) begin
         touch_time += hold_step();
         if ($urandom_range(0, 1) == 1) begin
            queue_report(COUNT_BITS'($urandom_range(2, 15)), x, y, touch_time);
         end else begin
            stray = (aim == ZONE_CANCEL) ? ZONE_CONFIRM : ZONE_CANCEL;
            pick_point(stray, x, y);
            queue_report(1, x, y, touch_time);
         end
      end
      touch_time += hold_step();
      queue_report(0, COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                   touch_time);
   endtask

   initial begin : stimulus
      int y_lo, y_hi, c_hi, f_lo, f_hi, hold_ms;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed reports under the reset settings: band rows 240..319, cancel up to
      // column 79, confirm 92..171, 30 ms debounce.
      gap_odds = 3;
      stall_odds = 3;
      queue_report(0, 1023, 1023, 32'hFFFF_FFFF);     // release while idle
      queue_report(1, 0, 240, 100);                   // cancel corner, debounce starts
      queue_report(1, 79, 319, 129);                  // 29 ms, still debouncing
      queue_report(1, 40, 280, 130);                  // 30 ms, now held
      queue_report(0, 0, 0, 510);                     // clean release of cancel
      queue_report(1, 171, 319, 32'hFFFF_FFF0);       // confirm corner near the wrap
      queue_report(1, 92, 240, 32'h0000_000E);        // 30 ms across the wrap, held
      queue_report(2, 92, 240, 20);                   // second finger blocks, no release
      queue_report(15, 0, 0, 30);
      queue_report(0, 0, 0, 31);
      queue_report(1, 80, 250, 40);                   // gap between zones blocks
      queue_report(0, 0, 0, 41);
      queue_report(3, 10, 250, 60);                   // several fingers at once block
      queue_report(0, 0, 0, 61);
      queue_report(1, 10, 320, 70);                   // just above the band blocks
      queue_report(0, 0, 0, 71);
      queue_report(1, 10, 300, 80);                   // cancel, then slide to confirm
      queue_report(1, 100, 300, 200);
      queue_report(0, 0, 0, 201);
      queue_report(1, 120, 300, 300);                 // lift while still debouncing
      queue_report(0, 0, 0, 301);
      queue_report(1, 120, 300, 400);
      queue_report(1, 120, 300, 430);                 // held confirm
      queue_report(1, 172, 300, 440);                 // leaves the zone, no release
      queue_report(0, 0, 0, 441);
      wait_for_drain();

      // Zero debounce time still needs one report spent in debounce.
      apply_settings(RST_ACTION_Y_MIN, RST_ACTION_Y_MAX, RST_CANCEL_X_MAX,
                     RST_CONFIRM_X_MIN, RST_CONFIRM_X_MAX, 0);
      queue_report(1, 20, 260, 5000);
      queue_report(1, 20, 260, 5000);
      queue_report(0, 20, 260, 5000);
      wait_for_drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               y_lo = RST_ACTION_Y_MIN;  y_hi = RST_ACTION_Y_MAX;  c_hi = RST_CANCEL_X_MAX;
               f_lo = RST_CONFIRM_X_MIN; f_hi = RST_CONFIRM_X_MAX; hold_ms = RST_DEBOUNCE_TIME;
            end
            1: begin  // everything at zero: one band row, cancel covers confirm
               y_lo = 0; y_hi = 0; c_hi = 0; f_lo = 0; f_hi = 0; hold_ms = 0;
            end
            2: begin  // everything at its top value
               y_lo = 1023; y_hi = 1023; c_hi = 1023; f_lo = 1023; f_hi = 1023;
               hold_ms = 65535;
            end
            3: begin  // the whole screen is the band
               y_lo = 0; y_hi = 1023; c_hi = $urandom_range(0, 500);
               f_lo = c_hi + 1; f_hi = $urandom_range(f_lo, 1023); hold_ms = 0;
            end
            4: begin  // overlapping zones, cancel wins the shared columns
               y_lo = 100; y_hi = 700; c_hi = 200; f_lo = 100; f_hi = 400;
               hold_ms = $urandom_range(0, 50);
            end
            5: begin  // inverted band, nothing can be pressed
               y_lo = 600; y_hi = 300; c_hi = 300; f_lo = 400; f_hi = 800; hold_ms = 10;
            end
            6: begin  // inverted confirm range, only cancel exists
               y_lo = 200; y_hi = 900; c_hi = 150; f_lo = 700; f_hi = 300;
               hold_ms = $urandom_range(0, 20);
            end
            default: begin
               y_lo = $urandom_range(0, 1023);
               y_hi = $urandom_range(y_lo, 1023);
               c_hi = $urandom_range(0, 400);
               f_lo = $urandom_range(c_hi, 1023);
               f_hi = $urandom_range(f_lo, 1023);
               case (p % 3)
                  0: hold_ms = $urandom_range(0, 100);
                  1: hold_ms = $urandom_range(0, 65535);
                  default: hold_ms = $urandom_range(0, 8);
               endcase
            end
         endcase
         apply_settings(y_lo, y_hi, c_hi, f_lo, f_hi, hold_ms);

         // One middle phase and the closing phases run without any idling.
         gap_odds = (p == 3 || p >= PHASES - 2) ? 0 : $urandom_range(2, 8);
         stall_odds = (p == 3 || p >= PHASES - 2) ? 0 : $urandom_range(2, 8);
         touch_time = (p % 3 == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 6) == 0)
               queue_report(COUNT_BITS'($urandom_range(0, 15)),
                            COORD_W'($urandom_range(0, 1023)),
                            COORD_W'($urandom_range(0, 1023)),
                            ($urandom_range(0, 1) == 1) ? $urandom : touch_time);
            else
               queue_gesture();
         end
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (expected_zones.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_zones.size()));
      $display("Covered %0d touch reports under %0d register settings.",
               reports_accepted, settings_applied);
      $display("Responses held a zone %0d times and reported a clean release %0d times.",
               held_seen, released_seen);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
